// File: src/oriented_box_zone_flag_lookup_macros.svh
// ----------------------------------------------------------------------------
// Oriented box zone flag lookup: assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ORIENTED_BOX_ZONE_FLAG_LOOKUP_MACROS_SVH
`define ORIENTED_BOX_ZONE_FLAG_LOOKUP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define OBZF_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define OBZF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: src/obzf_pkg.sv
// ----------------------------------------------------------------------------
// Oriented box zone flag lookup: package
// Types and fixed widths shared by the front end, queue and back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package obzf_pkg;

  localparam int SLOT_W      = 12;
  localparam int POS_W       = 20;
  localparam int HALF_W      = 16;
  localparam int CFG_W       = 13;
  localparam int IN_TDATA_W  = 168;
  localparam int OUT_TDATA_W = 24;

  // Input tdata field offsets, lowest bit of each field.
  localparam int OFS_SLOT   = 0;
  localparam int OFS_POS_X  = 12;
  localparam int OFS_POS_Y  = 32;
  localparam int OFS_POS_Z  = 52;
  localparam int OFS_TOP_Z  = 72;
  localparam int OFS_E1_X   = 88;
  localparam int OFS_E1_Y   = 104;
  localparam int OFS_E2_X   = 120;
  localparam int OFS_E2_Y   = 136;
  localparam int OFS_FLAGS  = 152;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_QUERY = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_DRAIN,
    ST_DONE
  } back_state_t;

  // One stored zone, whole units.
  typedef struct packed {
    logic        [15:0] flags;
    logic signed [15:0] e2y;
    logic signed [15:0] e2x;
    logic signed [15:0] e1y;
    logic signed [15:0] e1x;
    logic signed [15:0] top;
    logic signed [15:0] bot;
    logic signed [15:0] cy;
    logic signed [15:0] cx;
  } zone_t;

  // Classified work item held in the queue.
  typedef struct packed {
    op_t                     op;
    logic [SLOT_W-1:0]       slot;
    logic signed [POS_W-1:0] px;
    logic signed [POS_W-1:0] py;
    logic signed [POS_W-1:0] pz;
    zone_t                   zone;
  } item_t;

endpackage

// File: src/obzf_front.sv
// ----------------------------------------------------------------------------
// Oriented box zone flag lookup: front end
// Accepts stream transactions, unpacks and classifies them, and pushes work
// items into the queue. Writes to slots beyond the table are dropped here.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module obzf_front #(
  parameter int MAX_ZONES = 4096
) (
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [obzf_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  input  logic                             s_axis_tuser,
  input  logic                             q_full,
  output logic                             q_push,
  output obzf_pkg::item_t                  q_item
);

  logic        in_slot_ok;
  obzf_pkg::op_t op;

  assign s_axis_tready = !q_full;

  always_comb begin
    case (s_axis_tuser)
      1'b1:    op = obzf_pkg::OP_QUERY;
      default: op = obzf_pkg::OP_WRITE;
    endcase
  end

  always_comb begin
    q_item.op   = op;
    q_item.slot = s_axis_tdata[obzf_pkg::OFS_SLOT +: obzf_pkg::SLOT_W];
    q_item.px   = s_axis_tdata[obzf_pkg::OFS_POS_X +: obzf_pkg::POS_W];
    q_item.py   = s_axis_tdata[obzf_pkg::OFS_POS_Y +: obzf_pkg::POS_W];
    q_item.pz   = s_axis_tdata[obzf_pkg::OFS_POS_Z +: obzf_pkg::POS_W];
    // Corner and bottom drop their fraction bits, rounding toward minus infinity.
    q_item.zone.cx    = s_axis_tdata[obzf_pkg::OFS_POS_X + 4 +: obzf_pkg::HALF_W];
    q_item.zone.cy    = s_axis_tdata[obzf_pkg::OFS_POS_Y + 4 +: obzf_pkg::HALF_W];
    q_item.zone.bot   = s_axis_tdata[obzf_pkg::OFS_POS_Z + 4 +: obzf_pkg::HALF_W];
    q_item.zone.top   = s_axis_tdata[obzf_pkg::OFS_TOP_Z +: obzf_pkg::HALF_W];
    q_item.zone.e1x   = s_axis_tdata[obzf_pkg::OFS_E1_X +: obzf_pkg::HALF_W];
    q_item.zone.e1y   = s_axis_tdata[obzf_pkg::OFS_E1_Y +: obzf_pkg::HALF_W];
    q_item.zone.e2x   = s_axis_tdata[obzf_pkg::OFS_E2_X +: obzf_pkg::HALF_W];
    q_item.zone.e2y   = s_axis_tdata[obzf_pkg::OFS_E2_Y +: obzf_pkg::HALF_W];
    q_item.zone.flags = s_axis_tdata[obzf_pkg::OFS_FLAGS +: obzf_pkg::HALF_W];
  end

  assign in_slot_ok = 32'(q_item.slot) < 32'(MAX_ZONES);

  // Out-of-range writes complete the transaction but never reach the queue.
  assign q_push = s_axis_tvalid && s_axis_tready &&
                  ((op == obzf_pkg::OP_QUERY) || in_slot_ok);

endmodule

// File: src/obzf_fifo.sv
// ----------------------------------------------------------------------------
// Oriented box zone flag lookup: work queue
// Two-entry queue of classified items between the front and back ends.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module obzf_fifo (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  obzf_pkg::item_t push_item,
  output logic            full,
  input  logic            pop,
  output logic            head_valid,
  output obzf_pkg::item_t head
);

  obzf_pkg::item_t entries [2];
  logic            wr_ptr;
  logic            rd_ptr;
  logic [1:0]      count;

  assign full       = (count == 2'd2);
  assign head_valid = (count != 2'd0);
  assign head       = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// File: src/obzf_back.sv
// ----------------------------------------------------------------------------
// Oriented box zone flag lookup: back end
// Owns the zone table. Stores write items and walks the table for queries
// through a read, offset, multiply and compare pipeline, one slot a cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module obzf_back #(
  parameter int MAX_ZONES = 4096
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             head_valid,
  input  obzf_pkg::item_t                  head,
  output logic                             pop,
  input  logic [obzf_pkg::CFG_W-1:0]       zone_count,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [obzf_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

  localparam int AW    = (MAX_ZONES > 1) ? $clog2(MAX_ZONES) : 1;
  localparam int CNT_W = $clog2(MAX_ZONES + 1);

  obzf_pkg::back_state_t state;
  obzf_pkg::back_state_t state_next;

  obzf_pkg::zone_t mem [MAX_ZONES];
  obzf_pkg::zone_t rd_zone;
  logic            rd_v;

  logic                    mem_we;
  logic                    start;
  logic                    issue;
  logic                    finish;
  logic                    busy_pipe;
  logic [CNT_W-1:0]        idx;
  logic [CNT_W-1:0]        walk_len;
  logic [CNT_W-1:0]        clamp_len;
  logic signed [19:0]      px;
  logic signed [19:0]      py;
  logic signed [19:0]      pz;

  // Stage 1: offsets and slab test.
  logic               s1_v;
  logic               s1_zok;
  logic signed [20:0] s1_dx;
  logic signed [20:0] s1_dy;
  logic signed [15:0] s1_e1x;
  logic signed [15:0] s1_e1y;
  logic signed [15:0] s1_e2x;
  logic signed [15:0] s1_e2y;
  logic [15:0]        s1_flags;
  logic signed [19:0] cx16;
  logic signed [19:0] cy16;
  logic signed [19:0] bot16;
  logic signed [19:0] top16;

  // Stage 2: products and squares.
  logic               s2_v;
  logic               s2_zok;
  logic signed [36:0] s2_a1x;
  logic signed [36:0] s2_a1y;
  logic signed [36:0] s2_a2x;
  logic signed [36:0] s2_a2y;
  logic signed [31:0] s2_q1x;
  logic signed [31:0] s2_q1y;
  logic signed [31:0] s2_q2x;
  logic signed [31:0] s2_q2y;
  logic [15:0]        s2_flags;

  // Stage 3: projections against squared lengths.
  logic               s3_v;
  logic               s3_hit;
  logic [15:0]        s3_flags;
  logic signed [37:0] p1;
  logic signed [37:0] p2;
  logic signed [37:0] l1;
  logic signed [37:0] l2;

  logic [15:0] acc_flags;
  logic        acc_any;

  assign clamp_len = (32'(zone_count) > 32'(MAX_ZONES)) ? CNT_W'(MAX_ZONES)
                                                         : CNT_W'(zone_count);
  assign busy_pipe = rd_v || s1_v || s2_v || s3_v;

  always_comb begin
    state_next = state;
    case (state)
      obzf_pkg::ST_IDLE: begin
        if (head_valid && (head.op == obzf_pkg::OP_QUERY)) begin
          state_next = (clamp_len == '0) ? obzf_pkg::ST_DRAIN : obzf_pkg::ST_WALK;
        end
      end
      obzf_pkg::ST_WALK: begin
        if (idx == walk_len - CNT_W'(1)) begin
          state_next = obzf_pkg::ST_DRAIN;
        end
      end
      obzf_pkg::ST_DRAIN: begin
        if (!busy_pipe) begin
          state_next = obzf_pkg::ST_DONE;
        end
      end
      obzf_pkg::ST_DONE: begin
        if (!m_axis_tvalid || m_axis_tready) begin
          state_next = obzf_pkg::ST_IDLE;
        end
      end
      default: state_next = obzf_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    pop    = 1'b0;
    mem_we = 1'b0;
    start  = 1'b0;
    issue  = 1'b0;
    finish = 1'b0;
    case (state)
      obzf_pkg::ST_IDLE: begin
        pop    = head_valid;
        mem_we = head_valid && (head.op == obzf_pkg::OP_WRITE);
        start  = head_valid && (head.op == obzf_pkg::OP_QUERY);
      end
      obzf_pkg::ST_WALK: issue = 1'b1;
      obzf_pkg::ST_DONE: finish = !m_axis_tvalid || m_axis_tready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= obzf_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Table memory: one write port for zone writes, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[AW'(head.slot)] <= head.zone;
    end
    rd_zone <= mem[idx[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (start) begin
      px       <= head.px;
      py       <= head.py;
      pz       <= head.pz;
      walk_len <= clamp_len;
      idx      <= '0;
    end else if (issue) begin
      idx <= idx + CNT_W'(1);
    end
  end

  always_comb begin
    cx16  = {rd_zone.cx, 4'b0000};
    cy16  = {rd_zone.cy, 4'b0000};
    bot16 = {rd_zone.bot, 4'b0000};
    top16 = {rd_zone.top, 4'b0000};
  end

  always_ff @(posedge clk) begin
    s1_zok   <= (bot16 < pz) && (pz < top16);
    s1_dx    <= 21'(px) - 21'(cx16);
    s1_dy    <= 21'(py) - 21'(cy16);
    s1_e1x   <= rd_zone.e1x;
    s1_e1y   <= rd_zone.e1y;
    s1_e2x   <= rd_zone.e2x;
    s1_e2y   <= rd_zone.e2y;
    s1_flags <= rd_zone.flags;

    s2_zok   <= s1_zok;
    s2_a1x   <= 37'(s1_e1x) * 37'(s1_dx);
    s2_a1y   <= 37'(s1_e1y) * 37'(s1_dy);
    s2_a2x   <= 37'(s1_e2x) * 37'(s1_dx);
    s2_a2y   <= 37'(s1_e2y) * 37'(s1_dy);
    s2_q1x   <= 32'(s1_e1x) * 32'(s1_e1x);
    s2_q1y   <= 32'(s1_e1y) * 32'(s1_e1y);
    s2_q2x   <= 32'(s1_e2x) * 32'(s1_e2x);
    s2_q2y   <= 32'(s1_e2y) * 32'(s1_e2y);
    s2_flags <= s1_flags;

    s3_hit   <= s2_zok && (p1 >= 38'sd0) && (p1 <= l1) && (p2 >= 38'sd0) && (p2 <= l2);
    s3_flags <= s2_flags;
  end

  // Squared lengths are scaled by 16 to match the 1/16 unit offsets.
  always_comb begin
    p1 = 38'(s2_a1x) + 38'(s2_a1y);
    p2 = 38'(s2_a2x) + 38'(s2_a2y);
    l1 = (38'(s2_q1x) + 38'(s2_q1y)) <<< 4;
    l2 = (38'(s2_q2x) + 38'(s2_q2y)) <<< 4;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_v <= 1'b0;
      s1_v <= 1'b0;
      s2_v <= 1'b0;
      s3_v <= 1'b0;
    end else begin
      rd_v <= issue;
      s1_v <= rd_v;
      s2_v <= s1_v;
      s3_v <= s2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc_flags <= '0;
      acc_any   <= 1'b0;
    end else if (s3_v && s3_hit) begin
      acc_flags <= acc_flags | s3_flags;
      acc_any   <= 1'b1;
    end
  end

  // Output register: holds a finished result while the queue keeps filling.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (finish) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      m_axis_tdata <= {7'b0000000, acc_any, acc_flags};
    end
  end

endmodule

// File: src/oriented_box_zone_flag_lookup.sv
// ----------------------------------------------------------------------------
// Oriented box zone flag lookup: top level
// Zone table with point-in-parallelogram queries that OR the matching flags.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one item per transaction. tuser = 1 is a point query,
//   tuser = 0 writes a zone into a table slot; writes produce no result.
//   m_axis returns one transaction per query with the ORed flags and a
//   match bit. cfg_wen/cfg_wdata set how many leading slots a query walks.
//   A write item is retired by the back end straight from its idle state.
//   A query reads the table one slot per cycle through a single memory
//   read port, walking N slots, N being the slot count (clamped to
//   MAX_ZONES). A query that walks no slot skips straight to draining.
//   A two-entry queue sits behind the input, so items keep being accepted
//   while a query walks or a result waits on a stalled receiver; once the
//   queue is full tready drops. A stalled result holds in the output
//   register and blocks only the next query from finishing.
//   Reset (rst, synchronous) empties the queue and pipeline and clears the
//   slot count; table contents are not cleared and a slot must be written
//   before any query walks over it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module oriented_box_zone_flag_lookup #(
  parameter int MAX_ZONES = 4096
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_wen,
  input  logic [obzf_pkg::CFG_W-1:0]       cfg_wdata,   // active_zone_count
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // slot[11:0], pos_x[31:12], pos_y[51:32], pos_z[71:52], top_z[87:72],
  // edge1_x[103:88], edge1_y[119:104], edge2_x[135:120], edge2_y[151:136],
  // zone_flags[167:152]
  input  logic [obzf_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  input  logic                             s_axis_tuser,   // kind
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // match_flags[15:0], any_match[16], zero fill [23:17]
  output logic [obzf_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

  logic [obzf_pkg::CFG_W-1:0] zone_count;
  logic                       q_full;
  logic                       q_push;
  logic                       q_pop;
  logic                       head_valid;
  obzf_pkg::item_t            push_item;
  obzf_pkg::item_t            head;

  always_ff @(posedge clk) begin
    if (rst) begin
      zone_count <= '0;
    end else if (cfg_wen) begin
      zone_count <= cfg_wdata;
    end
  end

  obzf_front #(
    .MAX_ZONES (MAX_ZONES)
  ) u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_item        (push_item)
  );

  obzf_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_item  (push_item),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (head_valid),
    .head       (head)
  );

  obzf_back #(
    .MAX_ZONES (MAX_ZONES)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .head_valid    (head_valid),
    .head          (head),
    .pop           (q_pop),
    .zone_count    (zone_count),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

// File: src/obzf_checker.sv
// ----------------------------------------------------------------------------
// Oriented box zone flag lookup: port checker
// Watches the top level's ports and checks result ordering and contents.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "oriented_box_zone_flag_lookup_macros.svh"

module obzf_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             s_axis_tvalid,
  input logic                             s_axis_tready,
  input logic                             s_axis_tuser,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [obzf_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

  logic        q_acc;
  logic        r_acc;
  logic [15:0] pending;

  assign q_acc = s_axis_tvalid && s_axis_tready && s_axis_tuser;
  assign r_acc = m_axis_tvalid && m_axis_tready;

  // Queries accepted whose result has not been delivered yet.
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + 16'(q_acc) - 16'(r_acc);
    end
  end

  `OBZF_ASSERT_NEXT(a_result_holds, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result changed while stalled")

  `OBZF_ASSERT_SAME(a_result_has_query, r_acc, pending != 16'd0, "result transaction without a pending query")

  `OBZF_ASSERT_SAME(a_flags_need_match, m_axis_tvalid && !m_axis_tdata[16], m_axis_tdata[15:0] == 16'h0000, "flags set without any match")

endmodule

bind oriented_box_zone_flag_lookup obzf_checker u_obzf_checker (.*);

// File: tb/sv/tb_oriented_box_zone_flag_lookup.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Oriented box zone flag lookup: testbench
// Streams zone writes and point queries into the block and predicts each
// query result from a local copy of the zone table and the slot count. It
// covers directed boundary points, random zones with aimed and noise queries,
// and a zero slot count, under varied back-pressure.
// ----------------------------------------------------------------------------

module tb_oriented_box_zone_flag_lookup;

  localparam int ZONES        = 4096;
  localparam int DRAIN_CYCLES = 16;
  localparam int CYCLE_LIMIT  = 400000;

  // Input tdata layout, first field in the lowest bits.
  typedef struct packed {
    logic        [15:0] zone_flags;
    logic signed [15:0] edge2_y;
    logic signed [15:0] edge2_x;
    logic signed [15:0] edge1_y;
    logic signed [15:0] edge1_x;
    logic signed [15:0] top_z;
    logic signed [19:0] pos_z;
    logic signed [19:0] pos_y;
    logic signed [19:0] pos_x;
    logic        [11:0] slot;
  } zone_fields_t;

  typedef struct {
    obzf_pkg::op_t kind;
    zone_fields_t  body;
  } zone_item_t;

  typedef struct packed {
    logic        any_match;
    logic [15:0] match_flags;
  } lookup_result_t;

  logic                             clk           = 1'b0;
  logic                             rst           = 1'b1;
  logic                             cfg_wen       = 1'b0;
  logic [obzf_pkg::CFG_W-1:0]       cfg_wdata     = '0;
  logic                             s_axis_tvalid = 1'b0;
  logic                             s_axis_tready;
  logic [obzf_pkg::IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic                             s_axis_tuser  = 1'b0;
  logic                             m_axis_tvalid;
  logic                             m_axis_tready = 1'b0;
  logic [obzf_pkg::OUT_TDATA_W-1:0] m_axis_tdata;

  oriented_box_zone_flag_lookup #(
    .MAX_ZONES(ZONES)
  ) DUT (
    .clk          (clk),
    .rst          (rst),
    .cfg_wen      (cfg_wen),
    .cfg_wdata    (cfg_wdata),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  obzf_pkg::zone_t zone_tbl [ZONES];      // table as the block should hold it
  int unsigned     zone_count = 0;        // active_zone_count as last written
  obzf_pkg::zone_t plan_tbl [ZONES];      // table as the queued stimulus leaves it
  bit              plan_written [ZONES];
  zone_item_t      pending_q [$];
  zone_item_t      in_flight;
  lookup_result_t  expected_lookups [$];
  lookup_result_t  seen, wanted;
  int              idle_mode   = 0;
  int              err_count   = 0;
  int              result_count = 0;
  int              cycle_count = 0;

  initial begin
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor

  function automatic bit zone_contains(obzf_pkg::zone_t z, longint px, longint py,
                                       longint pz);
    longint dx, dy, ax, ay, bx, by, p1, p2, l1, l2;
    if (longint'($signed(z.bot)) * 16 >= pz || longint'($signed(z.top)) * 16 <= pz)
      return 1'b0;
    dx = px - longint'($signed(z.cx)) * 16;
    dy = py - longint'($signed(z.cy)) * 16;
    ax = $signed(z.e1x);
    ay = $signed(z.e1y);
    bx = $signed(z.e2x);
    by = $signed(z.e2y);
    p1 = ax * dx + ay * dy;
    p2 = bx * dx + by * dy;
    l1 = (ax * ax + ay * ay) * 16;
    l2 = (bx * bx + by * by) * 16;
    return p1 >= 0 && p1 <= l1 && p2 >= 0 && p2 <= l2;
  endfunction

  function automatic lookup_result_t predict_lookup(longint px, longint py, longint pz);
    lookup_result_t r;
    int n;
    r = '0;
    // Counts above the table size walk the whole table.
    n = (zone_count > ZONES) ? ZONES : zone_count;
    for (int i = 0; i < n; i++) begin
      if (zone_contains(zone_tbl[i], px, py, pz)) begin
        r.match_flags |= zone_tbl[i].flags;
        r.any_match = 1'b1;
      end
    end
    return r;
  endfunction

  function automatic void apply_item(zone_item_t it);
    obzf_pkg::zone_t z;
    if (it.kind == obzf_pkg::OP_WRITE) begin
      // The fraction bits of the corner and the bottom are dropped.
      z.cx    = it.body.pos_x[19:4];
      z.cy    = it.body.pos_y[19:4];
      z.bot   = it.body.pos_z[19:4];
      z.top   = it.body.top_z;
      z.e1x   = it.body.edge1_x;
      z.e1y   = it.body.edge1_y;
      z.e2x   = it.body.edge2_x;
      z.e2y   = it.body.edge2_y;
      z.flags = it.body.zone_flags;
      zone_tbl[it.body.slot] = z;
    end else begin
      expected_lookups = {expected_lookups, predict_lookup($signed(it.body.pos_x),
                                                           $signed(it.body.pos_y),
                                                           $signed(it.body.pos_z))};
    end
  endfunction

  // ---------------------------------------------------------------- stimulus

  function automatic logic signed [19:0] sat20(longint v);
    if (v > 524287) return 20'h7FFFF;
    if (v < -524288) return 20'h80000;
    return v[19:0];
  endfunction

  function automatic longint noise_coord();
    return longint'($urandom_range(0, 1048575)) - 524288;
  endfunction

  function automatic int filled_prefix();
    int n;
    n = 0;
    while (n < ZONES && plan_written[n]) n++;
    return n;
  endfunction

  function automatic obzf_pkg::zone_t zone_of(int cx, int cy, int bot, int top, int e1x,
                                              int e1y, int e2x, int e2y, int flags);
    obzf_pkg::zone_t z;
    z.cx    = 16'(cx);
    z.cy    = 16'(cy);
    z.bot   = 16'(bot);
    z.top   = 16'(top);
    z.e1x   = 16'(e1x);
    z.e1y   = 16'(e1y);
    z.e2x   = 16'(e2x);
    z.e2y   = 16'(e2y);
    z.flags = 16'(flags);
    return z;
  endfunction

  function automatic void push_zone(int slot, obzf_pkg::zone_t z, bit frac_max);
    zone_item_t it;
    it.kind               = obzf_pkg::OP_WRITE;
    it.body.slot          = slot[11:0];
    it.body.pos_x         = {z.cx, frac_max ? 4'hF : 4'($urandom)};
    it.body.pos_y         = {z.cy, frac_max ? 4'hF : 4'($urandom)};
    it.body.pos_z         = {z.bot, frac_max ? 4'hF : 4'($urandom)};
    it.body.top_z         = z.top;
    it.body.edge1_x       = z.e1x;
    it.body.edge1_y       = z.e1y;
    it.body.edge2_x       = z.e2x;
    it.body.edge2_y       = z.e2y;
    it.body.zone_flags    = z.flags;
    plan_tbl[slot]        = z;
    plan_written[slot]    = 1'b1;
    pending_q = {pending_q, it};
  endfunction

  // Fields a query does not use carry random junk.
  function automatic void push_point(longint px, longint py, longint pz);
    zone_item_t it;
    it.kind       = obzf_pkg::OP_QUERY;
    it.body       = zone_fields_t'({$urandom, $urandom, $urandom, $urandom, $urandom,
                                    $urandom});
    it.body.pos_x = sat20(px);
    it.body.pos_y = sat20(py);
    it.body.pos_z = sat20(pz);
    pending_q = {pending_q, it};
  endfunction

  // Mostly small overlapping rectangles, sometimes a fully random zone.
  function automatic obzf_pkg::zone_t make_zone();
    obzf_pkg::zone_t z;
    int u, v, s;
    if ($urandom_range(0, 4) == 0) begin
      z = obzf_pkg::zone_t'({$urandom, $urandom, $urandom, $urandom, $urandom});
      return z;
    end
    u = $urandom_range(0, 120) - 60;
    v = $urandom_range(0, 120) - 60;
    s = $urandom_range(1, 3);
    z.cx    = 16'($urandom_range(0, 200) - 100);
    z.cy    = 16'($urandom_range(0, 200) - 100);
    z.e1x   = 16'(u);
    z.e1y   = 16'(v);
    z.e2x   = 16'(-v * s);
    z.e2y   = 16'(u * s);
    z.bot   = 16'($urandom_range(0, 200) - 100);
    z.top   = z.bot + 16'($urandom_range(1, 40));
    z.flags = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'(1) << $urandom_range(0, 15);
    return z;
  endfunction

  // Position along an edge in sixteenths, biased toward both bounds.
  function automatic longint edge_fraction();
    case ($urandom_range(0, 9))
      0: return 0;
      1: return 16;
      2: return -1;
      3: return 17;
      default: return longint'($urandom_range(0, 16));
    endcase
  endfunction

  function automatic void push_aimed_query(int j);
    obzf_pkg::zone_t z;
    longint a, b, lo, hi, pz;
    z  = plan_tbl[j];
    a  = edge_fraction();
    b  = edge_fraction();
    lo = longint'($signed(z.bot)) * 16;
    hi = longint'($signed(z.top)) * 16;
    case ($urandom_range(0, 5))
      0: pz = lo;
      1: pz = hi;
      2: pz = lo + 1;
      3: pz = hi - 1;
      default: pz = (hi - lo >= 2) ? lo + 1 + longint'($urandom_range(0, hi - lo - 2)) : lo + 1;
    endcase
    push_point(longint'($signed(z.cx)) * 16 + a * $signed(z.e1x) + b * $signed(z.e2x),
               longint'($signed(z.cy)) * 16 + a * $signed(z.e1y) + b * $signed(z.e2y), pz);
  endfunction

  function automatic void random_items(int n);
    int prefix, live, pick;
    for (int k = 0; k < n; k++) begin
      prefix = filled_prefix();
      live   = (zone_count > ZONES) ? ZONES : zone_count;
      pick   = $urandom_range(0, 99);
      if (pick < 30) begin
        pick = $urandom_range(0, 3);
        if (pick < 2)
          push_zone($urandom_range(0, ((live > 0) ? live : prefix) - 1), make_zone(), 1'b0);
        else if (pick == 2 && prefix < ZONES)
          push_zone(prefix, make_zone(), 1'b0);
        else
          push_zone($urandom_range(0, ZONES - 1), make_zone(), 1'b0);
      end else if (pick < 88 && live > 0) begin
        push_aimed_query($urandom_range(0, live - 1));
      end else begin
        push_point(noise_coord(), noise_coord(), noise_coord());
      end
    end
  endfunction

  // Sampled on the falling edge so the driver's updates at the rising edge
  // are already visible.
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_q.size() != 0 || s_axis_tvalid || expected_lookups.size() != 0);
    // Writes produce no result, so give the last of them time to retire.
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_zone_count(int unsigned n);
    wait_drained();
    cfg_wen   <= 1'b1;
    cfg_wdata <= n[obzf_pkg::CFG_W-1:0];
    @(posedge clk);
    cfg_wen    <= 1'b0;
    zone_count = n;
  endtask

  // ------------------------------------------------------- driver and monitor

  function automatic bit sender_gap();
    case (idle_mode)
      0: return $urandom_range(0, 99) < 29;
      1: return $urandom_range(0, 99) < 61;
      default: return 1'b0;
    endcase
  endfunction

  function automatic bit receiver_stall();
    case (idle_mode)
      0: return $urandom_range(0, 99) < 61;
      1: return $urandom_range(0, 99) < 29;
      default: return 1'b0;
    endcase
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) apply_item(in_flight);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_q.size() != 0 && !sender_gap()) begin
          in_flight = pending_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= in_flight.body;
          s_axis_tuser  <= in_flight.kind;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  task automatic log_mismatch(string what, logic [16:0] got_v, logic [16:0] want_v);
    $display("lookup result %0d: %s mismatch, got %h expected %h",
             result_count, what, got_v, want_v);
    err_count++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= !receiver_stall();
      if (m_axis_tvalid && m_axis_tready) begin
        seen = m_axis_tdata[16:0];
        result_count++;
        if (expected_lookups.size() == 0) begin
          log_mismatch("unrequested transaction", seen, '0);
        end else begin
          wanted = expected_lookups.pop_front();
          if (seen.match_flags !== wanted.match_flags)
            log_mismatch("match_flags", 17'(seen.match_flags), 17'(wanted.match_flags));
          if (seen.any_match !== wanted.any_match)
            log_mismatch("any_match", 17'(seen.any_match), 17'(wanted.any_match));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("oriented_box_zone_flag_lookup test failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    idle_mode = 0;

    // No slot is active after reset, so both come back empty.
    push_point(-524288, -524288, -524288);
    push_point(524287, 524287, 524287);

    // Slots 0, 2, 3 and 4 share a corner: a plain box, a box with a zero edge,
    // an inverted slab and an empty slab. Fraction bits must be dropped.
    push_zone(0, zone_of(10, 20, -2, 3, 8, 0, 0, 4, 'h0001), 1'b1);
    push_zone(1, zone_of(-100, -50, 0, 10, 3, 4, -8, 6, 'h0002), 1'b1);
    push_zone(2, zone_of(10, 20, -2, 3, 0, 0, 5, 0, 'h0004), 1'b0);
    push_zone(3, zone_of(10, 20, 5, 2, 8, 0, 0, 4, 'h0008), 1'b0);
    push_zone(4, zone_of(10, 20, 0, 0, 8, 0, 0, 4, 'h0010), 1'b0);
    push_zone(5, zone_of(-32768, -32768, -32768, 32767, 32767, 0, 0, 32767, 'h8000), 1'b1);
    push_zone(6, zone_of(32767, 32767, -32768, 32767, -32768, 0, 0, -32768, 'h4000), 1'b0);
    push_zone(7, zone_of(0, 0, -1, 1, 1, 1, 1, -1, 'hFFFF), 1'b0);

    set_zone_count(8);
    push_point(224, 352, 0);
    push_point(160, 320, 0);
    push_point(288, 384, 0);
    push_point(289, 352, 0);
    push_point(224, 319, 0);
    push_point(224, 352, -32);
    push_point(224, 352, -31);
    push_point(224, 352, 48);
    push_point(224, 352, 47);
    push_point(-1640, -720, 16);
    push_point(0, 0, 0);
    push_point(-524288, -524288, 0);
    push_point(524287, 524287, 0);
    random_items(40);

    set_zone_count($urandom_range(1, filled_prefix()));
    idle_mode = 1;
    random_items(40);

    set_zone_count(0);
    idle_mode = 2;
    push_point(noise_coord(), noise_coord(), noise_coord());
    push_point(0, 0, 0);

    set_zone_count($urandom_range(1, filled_prefix()));
    random_items(40);
    wait_drained();

    if (err_count == 0)
      $display("oriented_box_zone_flag_lookup test passed");
    else
      $display("oriented_box_zone_flag_lookup test failed");
    $finish;
  end

endmodule

// File: files.f
+incdir+src
src/obzf_pkg.sv
src/obzf_front.sv
src/obzf_fifo.sv
src/obzf_back.sv
src/oriented_box_zone_flag_lookup.sv
src/obzf_checker.sv
tb/sv/tb_oriented_box_zone_flag_lookup.sv
